### src/iis_pkg.sv
// shared constants and types for the streaming integral image block
package iis_pkg;

    // fixed field widths
    localparam int PIXEL_W    = 8;
    localparam int ROW_SUM_W  = 18;
    localparam int AREA_SUM_W = 28;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    // wide enough for any size up to 4096 and for an 11-bit register value
    localparam int SIZE_W     = 13;

    // default line store and frame limits
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET  = 11'd20;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 11'd15;

    // position flags of one pixel, passed from the position tracker
    typedef struct packed {
        logic first_row;
        logic row_end;
        logic frame_end;
    } pos_flags_t;

endpackage

### src/iis_pos.sv
// raster position counters and running row sum
module iis_pos #(
    parameter int MAX_WIDTH  = iis_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = iis_pkg::DEFAULT_MAX_HEIGHT,
    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [iis_pkg::PIXEL_W-1:0]     pixel_value,
    input  logic [iis_pkg::CFG_DATA_W-1:0]  image_width,
    input  logic [iis_pkg::CFG_DATA_W-1:0]  image_height,
    output logic [COL_W-1:0]                col_addr,
    output logic [iis_pkg::ROW_SUM_W-1:0]   row_sum,
    output iis_pkg::pos_flags_t             flags
);

    logic [COL_W-1:0]               col_reg, col_next;
    logic [ROW_W-1:0]               row_reg, row_next;
    logic [iis_pkg::ROW_SUM_W-1:0]  row_sum_reg, row_sum_next;
    logic [iis_pkg::SIZE_W-1:0]     width_ext, height_ext;
    logic [iis_pkg::SIZE_W-1:0]     width_eff, height_eff;
    logic                           row_end, frame_end;

    // zero acts as one, oversize is clamped
    always_comb begin
        width_ext  = iis_pkg::SIZE_W'(image_width);
        height_ext = iis_pkg::SIZE_W'(image_height);
        if (width_ext == '0) begin
            width_eff = iis_pkg::SIZE_W'(1);
        end else if (width_ext > iis_pkg::SIZE_W'(MAX_WIDTH)) begin
            width_eff = iis_pkg::SIZE_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        if (height_ext == '0) begin
            height_eff = iis_pkg::SIZE_W'(1);
        end else if (height_ext > iis_pkg::SIZE_W'(MAX_HEIGHT)) begin
            height_eff = iis_pkg::SIZE_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_ext;
        end
    end

    assign row_end   = iis_pkg::SIZE_W'(col_reg) >= (width_eff - iis_pkg::SIZE_W'(1));
    assign frame_end = row_end &&
                       (iis_pkg::SIZE_W'(row_reg) >= (height_eff - iis_pkg::SIZE_W'(1)));

    always_comb begin
        if (col_reg == '0) begin
            row_sum_next = iis_pkg::ROW_SUM_W'(pixel_value);
        end else begin
            row_sum_next = row_sum_reg + iis_pkg::ROW_SUM_W'(pixel_value);
        end
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_sum_reg <= '0;
        end else if (accept) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            row_sum_reg <= row_sum_next;
        end
    end

    assign col_addr        = col_reg;
    assign row_sum         = row_sum_next;
    assign flags.first_row = (row_reg == '0);
    assign flags.row_end   = row_end;
    assign flags.frame_end = frame_end;

endmodule

### src/iis_line_buf.sv
// line store of previous row integral values, one read and one write port
module iis_line_buf #(
    parameter int MAX_WIDTH = iis_pkg::DEFAULT_MAX_WIDTH,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [COL_W-1:0]                 rd_addr,
    output logic [iis_pkg::AREA_SUM_W-1:0]   rd_data,
    input  logic                             wr_en,
    input  logic [COL_W-1:0]                 wr_addr,
    input  logic [iis_pkg::AREA_SUM_W-1:0]   wr_data
);

    logic [iis_pkg::AREA_SUM_W-1:0] line_mem [MAX_WIDTH];
    logic [iis_pkg::AREA_SUM_W-1:0] rd_data_reg;

    // write-first: a read of the entry being written takes the new value
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= line_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/integral_image_stream.sv
// streaming integral image: an accepted pixel is registered in stage 1, then in the output register, for the m_ ports
// throughput one pixel per cycle while m_ready holds, set by the registered line store read and row sum adder
// a pixel at the same column as the one ahead of it takes the sum by write-first forwarding
// reset (aresetn low, synchronous) clears counters, row sum, pipeline valids and registers
// width and height return to 20 and 15; line store contents stay undefined until written
module integral_image_stream #(
    parameter int MAX_WIDTH  = iis_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = iis_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iis_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [iis_pkg::PIXEL_W-1:0]       s_pixel_value,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [iis_pkg::AREA_SUM_W-1:0]    m_area_sum,
    output logic                              m_row_end,
    output logic                              m_frame_end
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // configuration registers
    logic [iis_pkg::CFG_DATA_W-1:0]  image_width_reg, image_width_next;
    logic [iis_pkg::CFG_DATA_W-1:0]  image_height_reg, image_height_next;

    // stage 0 outputs (current pixel)
    logic                            s_accept;
    logic [COL_W-1:0]                pos_col;
    logic [iis_pkg::ROW_SUM_W-1:0]   pos_row_sum;
    iis_pkg::pos_flags_t             pos_flags;

    // stage 1: line store data arrives, integral value is formed
    logic                            s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]                s1_col_reg;
    logic [iis_pkg::ROW_SUM_W-1:0]   s1_row_sum_reg;
    iis_pkg::pos_flags_t             s1_flags_reg;
    logic                            s1_advance;
    logic [iis_pkg::AREA_SUM_W-1:0]  above;
    logic [iis_pkg::AREA_SUM_W-1:0]  total;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [iis_pkg::AREA_SUM_W-1:0]  out_sum_reg;
    logic                            out_row_end_reg;
    logic                            out_frame_end_reg;

    // ---------------------------------------------------------------
    // configuration: always ready, unknown indexes are dropped
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_comb begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                iis_pkg::REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                iis_pkg::REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= iis_pkg::IMAGE_WIDTH_RESET;
            image_height_reg <= iis_pkg::IMAGE_HEIGHT_RESET;
        end else begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // ---------------------------------------------------------------
    // handshake: stage 1 moves on when the output register is free or
    // being emptied; a new pixel enters when stage 1 is free or moving
    // ---------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    // position tracking and running row sum
    iis_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .pixel_value  (s_pixel_value),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .col_addr     (pos_col),
        .row_sum      (pos_row_sum),
        .flags        (pos_flags)
    );

    // line store: read issued on the accepting edge, written back as the
    // pixel leaves stage 1; same-edge hits on one column are forwarded
    iis_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (pos_col),
        .rd_data (above),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (total)
    );

    // first row takes nothing from above
    assign total = iis_pkg::AREA_SUM_W'(s1_row_sum_reg) +
                   (s1_flags_reg.first_row ? '0 : above);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_col_reg     <= pos_col;
            s1_row_sum_reg <= pos_row_sum;
            s1_flags_reg   <= pos_flags;
        end
        if (s1_advance) begin
            out_sum_reg       <= total;
            out_row_end_reg   <= s1_flags_reg.row_end;
            out_frame_end_reg <= s1_flags_reg.frame_end;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_area_sum  = out_sum_reg;
    assign m_row_end   = out_row_end_reg;
    assign m_frame_end = out_frame_end_reg;

endmodule
